// ===== hdl/esc485_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc485_pkg
// Shared constants and types for the escaped serial to RS-485 bridge.
// ----------------------------------------------------------------------------
package esc485_pkg;

  // Default frame length limit
  localparam int MAX_FRAME_BYTES_DEF = 10;

  // Escape scheme bytes
  localparam logic [7:0] ESC_BYTE   = 8'hAA;
  localparam logic [7:0] START_BYTE = 8'h01;

  // Frame opcodes
  localparam logic [7:0] OP_RESET = 8'h01;
  localparam logic [7:0] OP_COLOR = 8'h02;
  localparam logic [7:0] OP_FADE  = 8'h03;

  // Bus word constants
  localparam logic [8:0] ADDR_FLAG  = 9'h100;
  localparam logic [8:0] COLOR_WORD = 9'h002;

  // Frame bytes kept, and the frame positions that trigger actions
  localparam int KEPT_BYTES  = 5;
  localparam int KEEP_IDX_W  = 3;
  localparam int RESET_COUNT = 1;
  localparam int COLOR_COUNT = 5;
  localparam int FADE_COUNT  = 6;

  // Word position inside a set-colour run
  typedef enum logic [2:0] {
    W_ADDR,
    W_OPCODE,
    W_RED,
    W_GREEN,
    W_BLUE
  } word_sel_t;

  // One run of results produced by a single byte
  typedef struct packed {
    logic       reset_req;
    logic [7:0] addr;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } run_t;

endpackage
`default_nettype wire

// ===== hdl/esc485_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc485 channel interfaces
// Valid/ready channels for received bytes and for bus words.
// ----------------------------------------------------------------------------
interface esc485_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface esc485_word_if;
  logic       valid;
  logic       ready;
  logic [8:0] bus_word;
  logic       reset_request;
  logic       send_ack;
  logic       last;

  modport source (output valid, output bus_word, output reset_request,
                  output send_ack, output last, input ready);
  modport sink   (input valid, input bus_word, input reset_request,
                  input send_ack, input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/esc485_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// esc485_parser
// Undoes the byte escaping, tracks the frame and decodes opcodes. One byte
// is handled per accepted beat; a byte completing a set-colour or soft-reset command yields a run.
// ----------------------------------------------------------------------------
module esc485_parser #(
  parameter int MAX_FRAME_BYTES = esc485_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             byte_fire,
  input  wire logic [7:0]       rx_byte,
  output logic                  run_valid,
  output esc485_pkg::run_t      run
);
  import esc485_pkg::*;

  localparam int CNT_W  = $clog2(MAX_FRAME_BYTES);
  localparam int CNT1_W = CNT_W + 1;

  logic              esc_r, esc_nxt;
  logic              active_r, active_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0]        fb_r [KEPT_BYTES];

  logic              pass;
  logic              fb_we;
  logic [CNT1_W-1:0] count1;
  logic [7:0]        op;

  // Escape removal, frame tracking and opcode decode
  always_comb begin
    esc_nxt    = esc_r;
    active_nxt = active_r;
    count_nxt  = count_r;
    pass       = 1'b0;
    fb_we      = 1'b0;
    run_valid  = 1'b0;
    count1     = CNT1_W'(count_r) + CNT1_W'(1);
    // first byte of the frame is the one arriving now
    op         = (count_r == '0) ? rx_byte : fb_r[0];

    run.reset_req = 1'b0;
    run.addr      = fb_r[1];
    run.red       = fb_r[2];
    run.green     = fb_r[3];
    run.blue      = rx_byte;

    if (rx_byte == ESC_BYTE) begin
      esc_nxt = !esc_r;
      pass    = esc_r;
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      if (rx_byte == START_BYTE) begin
        active_nxt = 1'b1;
        count_nxt  = '0;
      end else begin
        pass = 1'b1;
      end
    end else begin
      pass = 1'b1;
    end

    if (pass && active_r) begin
      fb_we = (count_r < CNT_W'(KEPT_BYTES));
      if (count1 >= CNT1_W'(MAX_FRAME_BYTES)) begin
        active_nxt = 1'b0;
        count_nxt  = '0;
      end else begin
        count_nxt = count1[CNT_W-1:0];
      end

      if (op == OP_RESET && count1 == CNT1_W'(RESET_COUNT)) begin
        // soft reset: back to the idle state
        run_valid     = 1'b1;
        run.reset_req = 1'b1;
        esc_nxt       = 1'b0;
        active_nxt    = 1'b0;
        count_nxt     = '0;
      end else if (op == OP_COLOR && count1 == CNT1_W'(COLOR_COUNT)) begin
        run_valid  = 1'b1;
        active_nxt = 1'b0;
        count_nxt  = '0;
      end else if (op == OP_FADE && count1 == CNT1_W'(FADE_COUNT)) begin
        active_nxt = 1'b0;
        count_nxt  = '0;
      end
    end

    run_valid = run_valid && byte_fire;
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r    <= 1'b0;
      active_r <= 1'b0;
      count_r  <= '0;
    end else if (byte_fire) begin
      esc_r    <= esc_nxt;
      active_r <= active_nxt;
      count_r  <= count_nxt;
    end
  end

  // Kept frame bytes, no reset: only read after being written
  always_ff @(posedge clk) begin
    if (byte_fire && fb_we) begin
      fb_r[count_r[KEEP_IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/escaped_serial_to_rs485_bridge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_serial_to_rs485_bridge
// Turns escaped serial bytes into 9-bit RS-485 bus words.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one received byte per beat (valid/ready).
//   out_ch : one bus word per beat, with reset_request, send_ack and last.
//   A byte is decoded in the cycle it is accepted; any run of results it
//   causes is registered into the run queue, from which its first word is
//   presented. A set-colour run is five beats, a soft-reset run one beat;
//   last marks the final beat of each run.
//   Throughput: one byte per cycle while in_ready is high. The run queue
//   holds the run being sent and one waiting run, so bytes keep flowing
//   while a run drains; in_ready only drops while a second run waits
//   behind the one being sent.
//   When the receiver stalls, the current word holds and in_ready falls
//   once a waiting run is queued.
//   Reset (rst_n low, synchronous) clears the escape and frame state and
//   empties the run queue. A soft-reset command does the same to the frame
//   state when its byte is accepted, and its result is queued.
// ----------------------------------------------------------------------------
module escaped_serial_to_rs485_bridge #(
  parameter int MAX_FRAME_BYTES = esc485_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  esc485_byte_if.sink   in_ch,
  esc485_word_if.source out_ch
);
  import esc485_pkg::*;

  logic      in_fire, out_fire, last_word, act_free;
  logic      new_v;
  run_t      new_run;

  run_t      act_r, act_nxt;
  logic      act_v_r, act_v_nxt;
  word_sel_t idx_r, idx_nxt;
  run_t      wait_r, wait_nxt;
  logic      wait_v_r, wait_v_nxt;

  assign in_ch.ready = !wait_v_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  esc485_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (in_fire),
    .rx_byte   (in_ch.rx_byte),
    .run_valid (new_v),
    .run       (new_run)
  );

  // Word selection for the run being sent
  assign last_word = act_r.reset_req || (idx_r == W_BLUE);
  assign out_ch.valid = act_v_r;
  assign out_ch.last  = last_word;
  assign out_ch.reset_request = act_r.reset_req;
  assign out_ch.send_ack = !act_r.reset_req && (idx_r == W_BLUE);

  always_comb begin
    if (act_r.reset_req) begin
      out_ch.bus_word = '0;
    end else begin
      case (idx_r)
        W_ADDR:   out_ch.bus_word = ADDR_FLAG | {1'b0, act_r.addr};
        W_OPCODE: out_ch.bus_word = COLOR_WORD;
        W_RED:    out_ch.bus_word = {1'b0, act_r.red};
        W_GREEN:  out_ch.bus_word = {1'b0, act_r.green};
        default:  out_ch.bus_word = {1'b0, act_r.blue};
      endcase
    end
  end

  // Run queue: active run plus one waiting run
  assign act_free = !act_v_r || (out_fire && last_word);

  always_comb begin
    act_nxt    = act_r;
    act_v_nxt  = act_v_r;
    idx_nxt    = idx_r;
    wait_nxt   = wait_r;
    wait_v_nxt = wait_v_r;
    if (act_free) begin
      idx_nxt = W_ADDR;
      if (wait_v_r) begin
        act_nxt    = wait_r;
        act_v_nxt  = 1'b1;
        wait_nxt   = new_run;
        wait_v_nxt = new_v;
      end else begin
        act_nxt   = new_run;
        act_v_nxt = new_v;
      end
    end else begin
      if (out_fire) begin
        idx_nxt = word_sel_t'(idx_r + 3'd1);
      end
      if (new_v) begin
        wait_nxt   = new_run;
        wait_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_v_r  <= 1'b0;
      wait_v_r <= 1'b0;
      idx_r    <= W_ADDR;
    end else begin
      act_v_r  <= act_v_nxt;
      wait_v_r <= wait_v_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    wait_r <= wait_nxt;
  end

`ifndef SYNTHESIS
  // A run never waits behind an empty active slot
  a_wait_implies_active: assert property (@(posedge clk) disable iff (!rst_n)
    wait_v_r |-> act_v_r)
    else $error("waiting run with no active run");

  // A beat that is not the last of its run is followed by another word
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !last_word) |=> out_ch.valid)
    else $error("run ended before its last beat");

  // A soft-reset result never carries a bus word or acknowledge
  a_reset_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.reset_request) |->
      (out_ch.bus_word == '0 && !out_ch.send_ack && out_ch.last))
    else $error("malformed soft-reset beat");

  // Word index advances only with a delivered beat of a colour run
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (act_v_r && !out_fire) |=> $stable(idx_r))
    else $error("word index moved without a beat");
`endif

endmodule
`default_nettype wire

// ===== test/esc485_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// esc485_tb_pkg
// Bus word checker for the escaped serial to RS-485 bridge testbench. It
// follows the escape and frame decoding byte by byte, queues the bus words
// each accepted byte should cause, and compares every delivered beat with
// the oldest queued word.
// ----------------------------------------------------------------------------
package esc485_tb_pkg;
  import esc485_pkg::*;

  // One output beat, field for field as the word channel carries it
  typedef struct packed {
    logic [8:0] word;
    logic       reset_req;
    logic       ack;
    logic       last_beat;
  } bus_beat_t;

  class bus_word_checker;
    bus_beat_t   expected_beats[$];
    int unsigned errors;
    bit          esc_seen;
    bit          in_frame;
    logic [3:0]  frame_len;
    logic [7:0]  kept[KEPT_BYTES];

    function new();
      errors = 0;
      clear_decoder();
    endfunction

    // Power-on state; a soft-reset command brings the decoder back here too
    function void clear_decoder();
      esc_seen  = 1'b0;
      in_frame  = 1'b0;
      frame_len = '0;
      foreach (kept[i]) kept[i] = '0;
    endfunction

    function void push_beat(logic [8:0] w, logic r, logic a, logic l);
      bus_beat_t bt;
      bt.word      = w;
      bt.reset_req = r;
      bt.ack       = a;
      bt.last_beat = l;
      expected_beats.push_back(bt);
    endfunction

    // Decode one accepted byte. Returns 1 when the byte did something
    // (escape handling or a frame byte), 0 when it was simply dropped.
    function bit note_byte(logic [7:0] b);
      logic [4:0] n;
      logic [7:0] op;
      if (b == ESC_BYTE) begin
        if (!esc_seen) begin
          esc_seen = 1'b1;
          return 1'b1;
        end
        // doubled escape: literal 0xAA falls through as data
        esc_seen = 1'b0;
      end else if (esc_seen) begin
        esc_seen = 1'b0;
        if (b == START_BYTE) begin
          // frame start, also drops any frame in progress
          in_frame  = 1'b1;
          frame_len = '0;
          return 1'b1;
        end
      end

      if (!in_frame) return 1'b0;

      if (frame_len < KEPT_BYTES) kept[frame_len] = b;
      n = {1'b0, frame_len} + 5'd1;
      if (n >= MAX_FRAME_BYTES_DEF) begin
        in_frame  = 1'b0;
        frame_len = '0;
      end else begin
        frame_len = n[3:0];
      end

      op = kept[0];
      if (op == OP_RESET && n == RESET_COUNT) begin
        push_beat('0, 1'b1, 1'b0, 1'b1);
        clear_decoder();
      end else if (op == OP_COLOR && n == COLOR_COUNT) begin
        push_beat(ADDR_FLAG | {1'b0, kept[1]}, 1'b0, 1'b0, 1'b0);
        push_beat(COLOR_WORD, 1'b0, 1'b0, 1'b0);
        push_beat({1'b0, kept[2]}, 1'b0, 1'b0, 1'b0);
        push_beat({1'b0, kept[3]}, 1'b0, 1'b0, 1'b0);
        push_beat({1'b0, kept[4]}, 1'b0, 1'b1, 1'b1);
        in_frame  = 1'b0;
        frame_len = '0;
      end else if (op == OP_FADE && n == FADE_COUNT) begin
        in_frame  = 1'b0;
        frame_len = '0;
      end
      return 1'b1;
    endfunction

    // Compare a delivered beat with the oldest expected one
    function void check_word(logic [8:0] w, logic r, logic a, logic l);
      bus_beat_t got;
      bus_beat_t want;
      got.word      = w;
      got.reset_req = r;
      got.ack       = a;
      got.last_beat = l;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected beat word=%h rst=%b ack=%b last=%b",
                   $realtime, w, r, a, l);
        return;
      end
      want = expected_beats.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch exp word=%h rst=%b ack=%b last=%b",
                   $realtime, want.word, want.reset_req, want.ack,
                   want.last_beat);
          $display("    got word=%h rst=%b ack=%b last=%b", w, r, a, l);
        end
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the escaped serial to RS-485 bridge. A short directed run
// covers ignored bytes, escaped data, set-colour, soft reset, restart inside
// a frame and fade; then mostly well-formed random frames mixed with noise
// and broken frames. Both channels idle at random, with one stretch at full
// rate, and every beat on the word channel is checked against the checker.
// ----------------------------------------------------------------------------
module tb_top;
  import esc485_pkg::*;
  import esc485_tb_pkg::*;

  localparam int RANDOM_USED = 370;

  logic clk;
  logic rst_n;
  bit   gaps_on;
  int   used_bytes;

  bus_word_checker sb;

  esc485_byte_if in_bus ();
  esc485_word_if out_bus ();

  escaped_serial_to_rs485_bridge u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Hard stop
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Word channel receiver: stalls at random unless gaps are off
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= !gaps_on || ($urandom_range(99) >= 26);
    end
  end

  // Check each delivered beat
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      sb.check_word(out_bus.bus_word, out_bus.reset_request, out_bus.send_ack,
                    out_bus.last);
  end

  // One byte beat; starts and ends just after a rising edge
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 26) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    void'(sb.note_byte(b));
    used_bytes++;
  endtask

  task automatic send_start();
    send_byte(ESC_BYTE);
    send_byte(START_BYTE);
  endtask

  // Frame data byte: 0xAA doubled, other bytes sometimes escaped
  // (0x01 never, that would be a frame start)
  task automatic send_data(input logic [7:0] b);
    if (b == ESC_BYTE) begin
      send_byte(ESC_BYTE);
    end else if (b != START_BYTE && $urandom_range(7) == 0) begin
      send_byte(ESC_BYTE);
    end
    send_byte(b);
  endtask

  // Random content, weighted towards the bytes the decoder cares about
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return ESC_BYTE;
    if (r < 25) return START_BYTE;
    if (r < 35) return 8'h00;
    if (r < 45) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Hold the sender off until the word queue has drained
  task automatic drain_words();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned kind;
    int unsigned len;
    int          seq_no;
    int          wait_cnt;
    logic [7:0]  op;

    sb         = new();
    gaps_on    = 1'b1;
    used_bytes = 0;
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.rx_byte <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bytes outside a frame are dropped
    send_byte(8'h00);
    send_byte(8'hFF);
    // set-colour with extreme address, literal 0xAA and an escaped data byte
    send_start();
    send_byte(OP_COLOR);
    send_byte(8'hFF);
    send_byte(ESC_BYTE);
    send_byte(ESC_BYTE);
    send_byte(8'h00);
    send_byte(ESC_BYTE);
    send_byte(8'h7E);
    // unknown opcode frame restarted by a new start, then soft reset
    send_start();
    send_byte(8'h05);
    send_start();
    send_byte(OP_RESET);
    // fade frame, six bytes
    send_start();
    send_byte(OP_FADE);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'h44);
    send_byte(8'h55);

    // Random frames, noise and broken frames
    seq_no     = 0;
    while (used_bytes < RANDOM_USED) begin
      seq_no++;
      gaps_on = !(seq_no >= 40 && seq_no < 60);
      if (seq_no == 30 || seq_no == 75) drain_words();
      kind = $urandom_range(99);
      if (kind < 45) begin
        // set-colour
        send_start();
        send_data(OP_COLOR);
        repeat (4) send_data(pick_byte());
      end else if (kind < 55) begin
        send_start();
        send_data(OP_RESET);
      end else if (kind < 65) begin
        // fade, sometimes with trailing bytes that must be dropped
        send_start();
        send_data(OP_FADE);
        repeat (5) send_data(pick_byte());
        if ($urandom_range(1) == 0) send_data(pick_byte());
      end else if (kind < 75) begin
        // unknown opcode, runs into the frame length limit or is cut short
        do op = pick_byte();
        while (op == OP_RESET || op == OP_COLOR || op == OP_FADE);
        send_start();
        send_data(op);
        len = $urandom_range(11);
        repeat (len) send_data(pick_byte());
      end else if (kind < 87) begin
        // known opcode, usually cut short (0x01 completes a soft reset); next sequence restarts
        send_start();
        send_data(8'($urandom_range(1, 3)));
        len = $urandom_range(3);
        repeat (len) send_data(pick_byte());
      end else begin
        // raw noise, including stray escapes
        len = $urandom_range(1, 4);
        repeat (len) send_byte(pick_byte());
      end
    end

    // Wind down and wait for outstanding words
    gaps_on = 1'b1;
    @(negedge clk);
    in_bus.valid <= 1'b0;
    wait_cnt = 0;
    while (sb.pending() != 0 && wait_cnt < 4000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (8) @(posedge clk);
    sb.errors += sb.pending();

    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
